// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked, and disabled while an active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed: label");

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition: label");

`endif

// File: src/sbid_pkg.sv
// ----------------------------------------------------------------------------
// sbid_pkg
// Types and constants for the stop-bit integer decoder.
// ----------------------------------------------------------------------------
package sbid_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned GROUP_W  = 7;
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned COUNT_W  = 3;

    localparam logic [BYTE_W-1:0]  STOP_MASK  = 8'b1000_0000;
    localparam logic [BYTE_W-1:0]  GROUP_MASK = 8'b0111_1111;
    localparam logic [COUNT_W-1:0] MAX_GROUPS = 3'd5;

    // width of an accumulator that can still take one more group
    localparam int unsigned ACC_KEEP_W = VALUE_W - GROUP_W;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_SPENT    = 2'd2,
        ST_TAIL     = 2'd3
    } t_status;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
    } t_in;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               value_valid;
        t_status            status;
        logic               message_done;
    } t_out;

    typedef struct packed {
        logic [VALUE_W-1:0] acc;
        logic [COUNT_W-1:0] gcount;
        logic               lzero;
        logic               err;
    } t_dec_state;

    typedef struct packed {
        logic       emit;
        t_out       res;
        t_dec_state nxt;
    } t_step;

endpackage

// File: src/sbid_step.sv
// ----------------------------------------------------------------------------
// sbid_step
// Combinational decode of one byte against the current decoder state.
// ----------------------------------------------------------------------------
module sbid_step
    import sbid_pkg::*;
(
    input  t_dec_state i_state,
    input  t_in        i_item,
    output t_step      o_step
);

    logic               stop;
    logic [GROUP_W-1:0] grp;
    logic               ovf;
    logic               lz_new;
    logic [VALUE_W-1:0] acc_new;
    logic [COUNT_W-1:0] gc_new;
    t_dec_state         cleared;

    assign stop    = |(i_item.data_byte & STOP_MASK);
    assign grp     = GROUP_W'(i_item.data_byte & GROUP_MASK);
    assign ovf     = (i_state.gcount >= MAX_GROUPS)
                   || (i_state.acc[VALUE_W-1:ACC_KEEP_W] != '0);
    assign lz_new  = (i_state.gcount == '0) ? (grp == '0) : i_state.lzero;
    assign acc_new = {i_state.acc[ACC_KEEP_W-1:0], grp};
    assign gc_new  = i_state.gcount + COUNT_W'(1);
    assign cleared = '{acc: '0, gcount: '0, lzero: 1'b0, err: 1'b0};

    always_comb begin
        o_step      = '0;
        o_step.nxt  = i_state;
        o_step.res.status = ST_OK;
        if (i_state.err) begin
            // swallow until the end of the message
            if (i_item.last_byte) begin
                o_step.nxt = cleared;
            end
        end else if (ovf) begin
            o_step.emit             = 1'b1;
            o_step.res.status       = ST_OVERFLOW;
            o_step.res.message_done = 1'b1;
            o_step.nxt              = cleared;
            o_step.nxt.err          = !i_item.last_byte;
        end else if (stop) begin
            o_step.emit = 1'b1;
            o_step.nxt  = cleared;
            if (lz_new && (gc_new > COUNT_W'(1))) begin
                o_step.res.status       = ST_SPENT;
                o_step.res.message_done = 1'b1;
                o_step.nxt.err          = !i_item.last_byte;
            end else begin
                o_step.res.value        = acc_new;
                o_step.res.value_valid  = 1'b1;
                o_step.res.message_done = i_item.last_byte;
            end
        end else if (i_item.last_byte) begin
            o_step.emit             = 1'b1;
            o_step.res.status       = ST_TAIL;
            o_step.res.message_done = 1'b1;
            o_step.nxt              = cleared;
        end else begin
            o_step.nxt.acc    = acc_new;
            o_step.nxt.gcount = gc_new;
            o_step.nxt.lzero  = lz_new;
        end
    end

endmodule

// File: src/stop_bit_integer_decoder.sv
// ----------------------------------------------------------------------------
// stop_bit_integer_decoder
// Decodes big-endian 7-bit groups with a stop flag into 32-bit values.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake                  | Payload
//  --------+-----------+----------------------------+---------------------
//  in      | input     | i_in_valid / o_in_ready    | i_in  (t_in)
//  out     | output    | o_out_valid / i_out_ready  | o_out (t_out)
//
//  One byte per cycle: each transfer is decoded in the same cycle it is
//  taken, state updates at that edge, any result lands in the output reg.
//  The result is valid in the cycle after its input transfer.
//  Input is ready whenever the output reg is empty or being drained, so a
//  stalled output only holds the input off while a result is waiting.
//  i_rst_n is synchronous, active low: clears decoder state and out valid.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stop_bit_integer_decoder
    import sbid_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);

    t_dec_state r_state, n_state;
    logic       r_out_valid, n_out_valid;
    t_out       r_out, n_out;
    t_step      step;
    logic       in_xfer;
    logic       out_xfer;

    // per-byte decode
    sbid_step u_step (
        .i_state (r_state),
        .i_item  (i_in),
        .o_step  (step)
    );

    assign out_xfer   = r_out_valid && i_out_ready;
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_xfer    = i_in_valid && o_in_ready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !out_xfer;
        n_out       = r_out;
        if (in_xfer) begin
            n_state = step.nxt;
            if (step.emit) begin
                n_out_valid = 1'b1;
                n_out       = step.res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // payload reg, no reset needed
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // a decoded value always carries ok status
    `ASSERT_CLK(a_value_ok, i_clk, i_rst_n, (r_out_valid && r_out.value_valid) |-> (r_out.status == ST_OK))
    // an error result ends the message and carries a zero value
    `ASSERT_CLK(a_err_res, i_clk, i_rst_n, (r_out_valid && !r_out.value_valid) |-> (r_out.message_done && (r_out.value == '0)))
    // group counter never passes the group limit
    `ASSERT_NEVER(a_gc_range, i_clk, i_rst_n, r_state.gcount > MAX_GROUPS)
    // the last byte of a message leaves the decoder clear
    `ASSERT_CLK(a_msg_clear, i_clk, i_rst_n, (in_xfer && i_in.last_byte) |=> (r_state == '0))

endmodule
